/* rtl/ppt_pkg.sv */
// Shared types and constants for the peer presence table.
// Used by ppt_ctrl, ppt_dpath and peer_presence_table; depends on nothing.
package ppt_pkg;

    localparam int KEY_W      = 64;
    localparam int STR_W      = 16;
    localparam int TIME_W     = 32;
    localparam int SLOT_W     = 4;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;
    localparam int AGE_S_W    = 23;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [OP_W-1:0] OP_NOTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_TOUCH = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_UPDATED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REPORT  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_KEY = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 4'd1;

    localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd60000;
    localparam logic [STR_W-1:0]  SELF_STRENGTH = 16'h8000;

    // age/1000 = ((age >> 3) * RECIP_125) >> 36, exact for any 32-bit age
    localparam int          AGE_SHIFT = 36;
    localparam logic [29:0] RECIP_125 = 30'd549755814;

    typedef enum logic [1:0] {
        KIND_NOTE,
        KIND_TOUCH,
        KIND_READ,
        KIND_IGNORE
    } item_kind_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic touch;
        logic write;
        logic age;
        logic mul;
        logic out_load;
    } ppt_cmd_t;

    typedef struct packed {
        item_kind_t kind;
        logic       scan_done;
        logic       out_free;
    } ppt_stat_t;

endpackage

/* rtl/ppt_ctrl.sv */
// Sequencer for the peer presence table: input handshake and per-item steps.
// Depends on ppt_pkg; drives the command struct of ppt_dpath.
module ppt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ppt_pkg::ppt_stat_t stat,
    output ppt_pkg::ppt_cmd_t  cmd
);
    import ppt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WRITE,
        S_RD_WAIT,
        S_AGE,
        S_MUL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.kind)
                    KIND_NOTE:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    KIND_TOUCH:
                    begin
                        cmd.touch  = 1'b1;
                        state_next = S_RD_WAIT;
                    end
                    KIND_READ:   state_next = S_RD_WAIT;
                    KIND_IGNORE: state_next = S_DONE;
                    default:     state_next = S_DONE;
                endcase
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                    state_next = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_RD_WAIT;
            end
            S_RD_WAIT: state_next = S_AGE;
            S_AGE:
            begin
                cmd.age    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/ppt_dpath.sv */
// Datapath of the peer presence table: slot memory, used bits, scan trackers,
// age arithmetic, config registers and the output register. Depends on ppt_pkg.
module ppt_dpath #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ppt_pkg::ppt_cmd_t                      cmd,
    output ppt_pkg::ppt_stat_t                     stat,
    input  logic [ppt_pkg::OP_W-1:0]               operation,
    input  logic [ppt_pkg::KEY_W-1:0]              peer_key,
    input  logic signed [ppt_pkg::STR_W-1:0]       signal_strength,
    input  logic [ppt_pkg::TIME_W-1:0]             now_ms,
    input  logic [ppt_pkg::SLOT_W-1:0]             slot_index,
    input  logic                                  cfg_write,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ppt_pkg::STATUS_W-1:0]           status,
    output logic [ppt_pkg::SLOT_W-1:0]             slot,
    output logic                                  entry_used,
    output logic                                  entry_is_self,
    output logic [ppt_pkg::KEY_W-1:0]              entry_key,
    output logic signed [ppt_pkg::STR_W-1:0]       entry_strength,
    output logic [ppt_pkg::AGE_S_W-1:0]            age_seconds,
    output logic                                  online
);
    import ppt_pkg::*;

    localparam int IDXW = $clog2(TABLE_SLOTS);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_SLOTS - 1);
    localparam int PROD_W = 59;

    // configuration
    logic [KEY_W-1:0]  self_key_reg;
    logic [TIME_W-1:0] window_reg;

    // table state; slot 0 timing/strength live in flops, its key is self_key
    logic [TABLE_SLOTS-1:0] used_reg;
    logic [STR_W-1:0]       self_str_reg;
    logic [TIME_W-1:0]      self_seen_reg;
    logic [KEY_W-1:0]       mem_key  [TABLE_SLOTS];
    logic [STR_W-1:0]       mem_str  [TABLE_SLOTS];
    logic [TIME_W-1:0]      mem_seen [TABLE_SLOTS];
    logic [KEY_W-1:0]       rd_key_q;
    logic [STR_W-1:0]       rd_str_q;
    logic [TIME_W-1:0]      rd_seen_q;
    logic [IDXW-1:0]        rd_addr;

    // latched item
    item_kind_t        kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [STR_W-1:0]  str_reg;
    logic [TIME_W-1:0] now_reg;

    // report target
    logic [IDXW-1:0]     rpt_addr_reg;
    logic [SLOT_W-1:0]   rpt_slot_reg;
    logic                rpt_in_range_reg;
    logic [STATUS_W-1:0] rpt_status_reg;

    // scan
    logic            scan_active_reg;
    logic [IDXW-1:0] scan_addr_reg;
    logic            eval_valid_reg;
    logic [IDXW-1:0] eval_idx_reg;
    logic            match_found_reg, free_found_reg;
    logic [IDXW-1:0] match_idx_reg, free_idx_reg, oldest_idx_reg;
    logic [TIME_W-1:0] oldest_age_reg;

    // report arithmetic
    logic              res_used_reg, res_self_reg;
    logic [KEY_W-1:0]  res_key_reg;
    logic [STR_W-1:0]  res_str_reg;
    logic [TIME_W-1:0] age_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              online_reg;

    logic out_valid_reg;

    item_kind_t        kind_in;
    logic              eval_self, used_j, eval_free;
    logic [KEY_W-1:0]  key_j;
    logic [TIME_W-1:0] age_j;
    logic [IDXW-1:0]   hit_idx;
    logic [STATUS_W-1:0] hit_status;
    logic              rpt_self;
    logic [TIME_W-1:0] seen_sel;

    always_comb
    begin
        case (operation)
            OP_NOTE:  kind_in = (peer_key == '0) ? KIND_IGNORE : KIND_NOTE;
            OP_TOUCH: kind_in = KIND_TOUCH;
            OP_READ:  kind_in = KIND_READ;
            default:  kind_in = KIND_IGNORE;
        endcase
    end

    assign rd_addr   = scan_active_reg ? scan_addr_reg : rpt_addr_reg;
    assign eval_self = (eval_idx_reg == '0);
    assign used_j    = used_reg[eval_idx_reg];
    assign key_j     = eval_self ? self_key_reg : rd_key_q;
    assign age_j     = now_reg - rd_seen_q;
    assign eval_free = !eval_self && !used_j;

    always_comb
    begin
        if (match_found_reg)
        begin
            hit_idx    = match_idx_reg;
            hit_status = ST_UPDATED;
        end
        else if (free_found_reg)
        begin
            hit_idx    = free_idx_reg;
            hit_status = ST_NEW;
        end
        else
        begin
            hit_idx    = oldest_idx_reg;
            hit_status = ST_EVICTED;
        end
    end

    assign rpt_self = rpt_in_range_reg && (rpt_addr_reg == '0);
    assign seen_sel = rpt_self ? self_seen_reg : rd_seen_q;

    assign stat.kind      = kind_reg;
    assign stat.scan_done = eval_valid_reg && (eval_idx_reg == LAST_IDX);
    assign stat.out_free  = !out_valid_reg || out_ready;

    // slot memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.write && (hit_idx != '0))
        begin
            mem_key[hit_idx]  <= key_reg;
            mem_str[hit_idx]  <= str_reg;
            mem_seen[hit_idx] <= now_reg;
        end
        rd_key_q  <= mem_key[rd_addr];
        rd_str_q  <= mem_str[rd_addr];
        rd_seen_q <= mem_seen[rd_addr];
    end

    // control and reset-valued state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_key_reg    <= '0;
            window_reg      <= WINDOW_RESET;
            used_reg        <= TABLE_SLOTS'(1);
            self_str_reg    <= SELF_STRENGTH;
            self_seen_reg   <= '0;
            kind_reg        <= KIND_IGNORE;
            scan_active_reg <= 1'b0;
            scan_addr_reg   <= '0;
            eval_valid_reg  <= 1'b0;
            eval_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_SELF_KEY: self_key_reg <= cfg_data;
                    CFG_WINDOW:   window_reg   <= cfg_data[TIME_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.load)
                kind_reg <= kind_in;
            if (cmd.touch)
                self_seen_reg <= now_reg;
            if (cmd.write)
            begin
                used_reg[hit_idx] <= 1'b1;
                if (hit_idx == '0)
                begin
                    self_str_reg  <= str_reg;
                    self_seen_reg <= now_reg;
                end
            end

            eval_valid_reg <= scan_active_reg;
            eval_idx_reg   <= scan_addr_reg;
            if (cmd.scan_start)
            begin
                scan_active_reg <= 1'b1;
                scan_addr_reg   <= '0;
            end
            else if (scan_active_reg)
            begin
                if (scan_addr_reg == LAST_IDX)
                    scan_active_reg <= 1'b0;
                else
                    scan_addr_reg <= scan_addr_reg + 1'b1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg          <= peer_key;
            str_reg          <= signal_strength;
            now_reg          <= now_ms;
            rpt_status_reg   <= (kind_in == KIND_IGNORE) ? ST_IGNORED : ST_REPORT;
            // only a read can name a slot past the table; touch always hits slot 0
            rpt_in_range_reg <= (kind_in != KIND_READ) ||
                                ({28'b0, slot_index} < 32'(TABLE_SLOTS));
            if (kind_in == KIND_READ)
            begin
                rpt_addr_reg <= IDXW'(slot_index);
                rpt_slot_reg <= slot_index;
            end
            else
            begin
                rpt_addr_reg <= '0;
                rpt_slot_reg <= '0;
            end
        end

        if (cmd.scan_start)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            oldest_age_reg  <= '0;
            oldest_idx_reg  <= IDXW'(1);
        end
        else if (eval_valid_reg)
        begin
            // lowest matching used slot, lowest free slot, oldest (ties: highest)
            if (used_j && (key_j == key_reg) && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= eval_idx_reg;
            end
            if (eval_free && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= eval_idx_reg;
            end
            if (!eval_self && (age_j >= oldest_age_reg))
            begin
                oldest_age_reg <= age_j;
                oldest_idx_reg <= eval_idx_reg;
            end
        end

        if (cmd.write)
        begin
            rpt_addr_reg     <= hit_idx;
            rpt_slot_reg     <= SLOT_W'(hit_idx);
            rpt_in_range_reg <= 1'b1;
            rpt_status_reg   <= hit_status;
        end

        if (cmd.age)
        begin
            res_self_reg <= rpt_self;
            res_used_reg <= rpt_in_range_reg ? used_reg[rpt_addr_reg] : 1'b0;
            res_key_reg  <= rpt_self ? self_key_reg : rd_key_q;
            res_str_reg  <= rpt_self ? self_str_reg : rd_str_q;
            age_reg      <= now_reg - seen_sel;
        end

        if (cmd.mul)
        begin
            prod_reg   <= {30'b0, age_reg[TIME_W-1:3]} * {29'b0, RECIP_125};
            online_reg <= (age_reg < window_reg);
        end

        if (cmd.out_load)
        begin
            status         <= rpt_status_reg;
            slot           <= '0;
            entry_used     <= 1'b0;
            entry_is_self  <= 1'b0;
            entry_key      <= '0;
            entry_strength <= '0;
            age_seconds    <= '0;
            online         <= 1'b0;
            if (kind_reg != KIND_IGNORE)
            begin
                slot          <= rpt_slot_reg;
                entry_is_self <= res_self_reg;
                if (res_used_reg)
                begin
                    entry_used     <= 1'b1;
                    entry_key      <= res_key_reg;
                    entry_strength <= res_str_reg;
                    age_seconds    <= prod_reg[AGE_SHIFT+AGE_S_W-1:AGE_SHIFT];
                    online         <= online_reg;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/peer_presence_table.sv */
// Peer presence table: note-seen scans every slot before its result; read and touch
// skip the scan, and ignored items go straight to the output register.
// One item at a time; the next is taken once the result sits in the output
// register. The scan rate is one slot per cycle, set by the single read port.
// Reset clears used bits at once (slot 0 used); no clearing pass is needed.
module peer_presence_table #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ppt_pkg::OP_W-1:0]               operation,
    input  logic [ppt_pkg::KEY_W-1:0]              peer_key,
    input  logic signed [ppt_pkg::STR_W-1:0]       signal_strength,
    input  logic [ppt_pkg::TIME_W-1:0]             now_ms,
    input  logic [ppt_pkg::SLOT_W-1:0]             slot_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ppt_pkg::STATUS_W-1:0]           status,
    output logic [ppt_pkg::SLOT_W-1:0]             slot,
    output logic                                  entry_used,
    output logic                                  entry_is_self,
    output logic [ppt_pkg::KEY_W-1:0]              entry_key,
    output logic signed [ppt_pkg::STR_W-1:0]       entry_strength,
    output logic [ppt_pkg::AGE_S_W-1:0]            age_seconds,
    output logic                                  online,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import ppt_pkg::*;

    ppt_cmd_t  cmd;
    ppt_stat_t stat;

    assign cfg_ready = 1'b1;

    ppt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppt_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .operation       (operation),
        .peer_key        (peer_key),
        .signal_strength (signal_strength),
        .now_ms          (now_ms),
        .slot_index      (slot_index),
        .cfg_write       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .slot            (slot),
        .entry_used      (entry_used),
        .entry_is_self   (entry_is_self),
        .entry_key       (entry_key),
        .entry_strength  (entry_strength),
        .age_seconds     (age_seconds),
        .online          (online)
    );

endmodule

/* dv/ppt_checker.sv */
// Scoreboard for the peer presence table: keeps its own copy of the slot table,
// predicts one report per accepted item and compares it with each output beat.
// Depends on ppt_pkg; instantiated by peer_presence_table_test.
module ppt_checker #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [ppt_pkg::OP_W-1:0]       operation,
    input  logic [ppt_pkg::KEY_W-1:0]      peer_key,
    input  logic [ppt_pkg::STR_W-1:0]      signal_strength,
    input  logic [ppt_pkg::TIME_W-1:0]     now_ms,
    input  logic [ppt_pkg::SLOT_W-1:0]     slot_index,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [ppt_pkg::STATUS_W-1:0]   status,
    input  logic [ppt_pkg::SLOT_W-1:0]     slot,
    input  logic                           entry_used,
    input  logic                           entry_is_self,
    input  logic [ppt_pkg::KEY_W-1:0]      entry_key,
    input  logic [ppt_pkg::STR_W-1:0]      entry_strength,
    input  logic [ppt_pkg::AGE_S_W-1:0]    age_seconds,
    input  logic                           online,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppt_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                used;
        logic                is_self;
        logic [KEY_W-1:0]    key;
        logic [STR_W-1:0]    strength;
        logic [AGE_S_W-1:0]  age_s;
        logic                online;
    } slot_report_t;

    logic [KEY_W-1:0]  self_key_r;
    logic [TIME_W-1:0] window_r;
    logic              peer_used [TABLE_SLOTS];
    logic [KEY_W-1:0]  peer_id   [TABLE_SLOTS];
    logic [STR_W-1:0]  peer_rssi [TABLE_SLOTS];
    logic [TIME_W-1:0] peer_seen [TABLE_SLOTS];

    slot_report_t expected_reports[$];
    slot_report_t want;

    function automatic slot_report_t describe_slot(logic [STATUS_W-1:0] st, int unsigned i,
                                                   logic [TIME_W-1:0] now_val);
        slot_report_t r;
        logic [TIME_W-1:0] age;
        r = '0;
        r.status = st;
        r.slot = SLOT_W'(i);
        if (i < TABLE_SLOTS)
        begin
            r.is_self = (i == 0);
            if (peer_used[i])
            begin
                age = now_val - peer_seen[i];
                r.used = 1'b1;
                r.key = (i == 0) ? self_key_r : peer_id[i];
                r.strength = peer_rssi[i];
                r.age_s = AGE_S_W'(age / 1000);
                r.online = (age < window_r);
            end
        end
        return r;
    endfunction

    // Updates the table for one item and returns the report it produces.
    function automatic slot_report_t apply_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                                logic [STR_W-1:0] rssi,
                                                logic [TIME_W-1:0] now_val,
                                                logic [SLOT_W-1:0] idx);
        slot_report_t r;
        int hit;
        logic [STATUS_W-1:0] st;
        logic [TIME_W-1:0] oldest;
        logic [TIME_W-1:0] age;
        r = '0;
        r.status = ST_IGNORED;
        hit = -1;
        case (op)
            OP_TOUCH:
            begin
                peer_seen[0] = now_val;
                r = describe_slot(ST_REPORT, 0, now_val);
            end
            OP_READ:
                r = describe_slot(ST_REPORT, idx, now_val);
            OP_NOTE:
                if (key != '0)
                begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                        if (hit < 0 && peer_used[i] && ((i == 0) ? self_key_r : peer_id[i]) == key)
                            hit = i;
                    st = ST_UPDATED;
                    if (hit < 0)
                    begin
                        st = ST_NEW;
                        for (int i = 1; i < TABLE_SLOTS; i++)
                            if (hit < 0 && !peer_used[i])
                                hit = i;
                    end
                    if (hit < 0)
                    begin
                        // table full: oldest wrapped age goes, ties to the highest slot
                        st = ST_EVICTED;
                        oldest = '0;
                        hit = 1;
                        for (int i = 1; i < TABLE_SLOTS; i++)
                        begin
                            age = now_val - peer_seen[i];
                            if (age >= oldest)
                            begin
                                oldest = age;
                                hit = i;
                            end
                        end
                    end
                    if (st != ST_UPDATED)
                    begin
                        peer_used[hit] = 1'b1;
                        peer_id[hit] = key;
                    end
                    peer_rssi[hit] = rssi;
                    peer_seen[hit] = now_val;
                    r = describe_slot(st, hit, now_val);
                end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] expected_val,
                                        logic [63:0] actual_val);
        if (actual_val !== expected_val)
        begin
            $error("%s: expected %0h, got %0h", name, expected_val, actual_val);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_key_r = '0;
            window_r = WINDOW_RESET;
            for (int i = 0; i < TABLE_SLOTS; i++)
            begin
                peer_used[i] = (i == 0);
                peer_id[i] = '0;
                peer_rssi[i] = (i == 0) ? SELF_STRENGTH : '0;
                peer_seen[i] = '0;
            end
            expected_reports.delete();
            fail_count = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d slot %0d",
                           status, slot);
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("status", want.status, status);
                    check_field("slot", want.slot, slot);
                    check_field("entry_used", want.used, entry_used);
                    check_field("entry_is_self", want.is_self, entry_is_self);
                    check_field("entry_key", want.key, entry_key);
                    check_field("entry_strength", want.strength, entry_strength);
                    check_field("age_seconds", want.age_s, age_seconds);
                    check_field("online", want.online, online);
                end
            end
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    CFG_SELF_KEY: self_key_r = cfg_data;
                    CFG_WINDOW:   window_r = cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            if (in_valid && in_ready)
                expected_reports.push_back(apply_item(operation, peer_key, signal_strength,
                                                      now_ms, slot_index));
            // registered so the stimulus side samples it without a race
            pending <= expected_reports.size();
        end
    end

endmodule

/* dv/peer_presence_table_test.sv */
// Top of the peer presence table testbench: clock, reset, stimulus and verdict.
// Depends on ppt_pkg, peer_presence_table and the ppt_checker scoreboard.
module peer_presence_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ppt_pkg::*;

    localparam int TABLE_SLOTS = 16;
    localparam int KEY_POOL    = 20;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 100;
    localparam int QUIET_LIMIT = 2000;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [OP_W-1:0]       operation = '0;
    logic [KEY_W-1:0]      peer_key = '0;
    logic signed [STR_W-1:0] signal_strength = '0;
    logic [TIME_W-1:0]     now_ms = '0;
    logic [SLOT_W-1:0]     slot_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_W-1:0]     slot;
    logic                  entry_used;
    logic                  entry_is_self;
    logic [KEY_W-1:0]      entry_key;
    logic signed [STR_W-1:0] entry_strength;
    logic [AGE_S_W-1:0]    age_seconds;
    logic                  online;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int                fail_count;
    int                pending;
    int                quiet = 0;
    bit                calm = 1'b0;
    logic [KEY_W-1:0]  self_key_now = '0;
    logic [TIME_W-1:0] clock_ms = '0;
    logic [KEY_W-1:0]  known_keys [KEY_POOL];

    peer_presence_table #(.TABLE_SLOTS(TABLE_SLOTS)) uut (.*);

    ppt_checker #(.TABLE_SLOTS(TABLE_SLOTS)) scoreboard (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // nothing accepted on any channel for too long means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet == QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin : result_sink
        int stall;
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // valid is lowered only before a gap, so back-to-back beats keep it high
    task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                             logic [STR_W-1:0] rssi, logic [TIME_W-1:0] t,
                             logic [SLOT_W-1:0] idx);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        peer_key <= key;
        signal_strength <= rssi;
        now_ms <= t;
        slot_index <= idx;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic reconfigure(logic [KEY_W-1:0] key, logic [TIME_W-1:0] window);
        drain();
        repeat (4) @(posedge clk);
        write_reg(CFG_SELF_KEY, key);
        write_reg(CFG_WINDOW, CFG_DATA_W'(window));
        cfg_valid <= 1'b0;
        self_key_now = key;
    endtask

    task automatic random_item();
        int pick;
        logic [OP_W-1:0] op;
        logic [KEY_W-1:0] key;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            ;
        else if (pick < 70)
            clock_ms += $urandom_range(0, 3000);
        else if (pick < 85)
            clock_ms += $urandom_range(50000, 70000);
        else
            clock_ms = $urandom();
        pick = $urandom_range(0, 99);
        op = (pick < 55) ? OP_NOTE : (pick < 65) ? OP_TOUCH : (pick < 95) ? OP_READ : OP_UNKNOWN;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            key = '0;
        else if (pick < 12)
            key = self_key_now;
        else if (pick < 90)
            key = known_keys[$urandom_range(0, KEY_POOL - 1)];
        else
            key = {$urandom(), $urandom()};
        send_item(op, key, STR_W'($urandom()), clock_ms, SLOT_W'($urandom_range(0, 15)));
    endtask

    initial
    begin : stimulus
        logic [TIME_W-1:0] windows [PHASES];
        logic [KEY_W-1:0]  selves  [PHASES];

        known_keys[0] = '1;
        for (int i = 1; i < KEY_POOL; i++)
            known_keys[i] = {$urandom(), $urandom()} | 64'h1;
        windows = '{32'hFFFF_FFFF, 32'd0, WINDOW_RESET, 32'd1500, $urandom()};
        selves = '{known_keys[3], '1, {$urandom(), $urandom()}, 64'd0, known_keys[7]};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: self key zero, window at its reset value
        send_item(OP_READ, '0, '0, 32'd5000, 4'd0);
        send_item(OP_TOUCH, '0, '0, 32'd1000, 4'd0);
        send_item(OP_READ, '0, '0, 32'd0, 4'd0);          // age wraps below last seen
        send_item(OP_NOTE, '0, 16'h1234, 32'd10, 4'd3);   // empty key
        send_item(OP_UNKNOWN, 64'h55, 16'h0001, 32'd10, 4'd0);
        send_item(OP_NOTE, '1, 16'h7FFF, 32'hFFFF_FFFF, 4'd0);
        send_item(OP_NOTE, 64'd1, 16'h8000, 32'd0, 4'd15);
        send_item(OP_NOTE, '1, 16'hFFFF, 32'd100, 4'd0);
        send_item(OP_READ, '0, '0, 32'd200, 4'd15);       // never written
        send_item(OP_READ, '0, '0, 32'd60099, 4'd1);      // just inside the window
        send_item(OP_READ, '0, '0, 32'd60100, 4'd1);      // at the window edge

        reconfigure(64'hA5A5_5A5A_0F0F_F0F0, 32'd0);
        send_item(OP_NOTE, 64'hA5A5_5A5A_0F0F_F0F0, 16'd123, 32'd7, 4'd0);
        send_item(OP_READ, '0, '0, 32'd7, 4'd0);

        // self key now collides with slot 1: slot 0 matches first
        reconfigure('1, 32'hFFFF_FFFF);
        send_item(OP_NOTE, '1, 16'h8001, 32'd300, 4'd0);
        send_item(OP_READ, '0, '0, 32'd300, 4'd1);
        send_item(OP_READ, '0, '0, 32'd300, 4'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            reconfigure(selves[p], windows[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 25 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                random_item();
            end
            calm = 1'b0;
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
